>>> src/npp_pkg.sv
// Package: shared types and constants for the nearest-point-on-polyline block.
`default_nettype none
package npp_pkg;
  localparam int CW   = 20;         // coordinate width, signed Q16.4
  localparam int RB   = 16;         // ratio fraction bits
  localparam int QW   = RB + 1;     // quotient width, ratio in [0,1]
  localparam int MW   = 22;         // shared multiplier operand width
  localparam int PW   = 2 * MW;     // product and accumulator width
  localparam int DW   = 2 * CW + 2; // divider operand width
  localparam int DSTW = 2 * CW + 1; // result distance width
  localparam int AW   = 3;          // APB address width

  localparam logic [AW-1:0] ADDR_ANCHOR_X = 3'd0;
  localparam logic [AW-1:0] ADDR_ANCHOR_Y = 3'd4;

  typedef struct packed {
    logic                 move_to;
    logic signed [CW-1:0] vertex_x;
    logic signed [CW-1:0] vertex_y;
    logic                 last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [CW-1:0] nearest_x;
    logic signed [CW-1:0] nearest_y;
    logic [DSTW-1:0]      distance_squared;
    logic                 found;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIFF, ST_NUM0, ST_NUM1, ST_DEN0, ST_DEN1, ST_DEN2, ST_DECIDE,
    ST_DIV, ST_FOOT0, ST_FOOT1, ST_FOOT2, ST_DIST0, ST_DIST1, ST_DIST2,
    ST_ENDB, ST_PICK, ST_UPDATE, ST_FINISH
  } state_t;
endpackage
`default_nettype wire

>>> src/nearest_point_on_polyline_top.sv
// Top level: vertex intake, sequencer around one shared multiplier, result register.
// A move-to vertex goes straight to the finish state. A segment needs four products for the
// ratio terms, a division for the ratio, two products for the foot and two for its distance
// when the anchor projects inside it, and two endpoint distances of two products each when
// an endpoint wins; vertex_stall is high whenever the sequencer is not idle. Every product
// goes through a single registered 22x22 multiplier, and the ratio comes from a bit-serial
// restoring divider. The result is held in an output register; a final vertex waits only
// if the previous result was not taken.
`default_nettype none
module nearest_point_on_polyline_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         vertex_valid,
  output logic                              vertex_stall,
  input  wire npp_pkg::vertex_t             vertex,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output npp_pkg::result_t                  result,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [npp_pkg::AW-1:0]       paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  localparam int CW = npp_pkg::CW;
  localparam int MW = npp_pkg::MW;
  localparam int PW = npp_pkg::PW;
  localparam logic signed [PW-1:0] DIST_MAX = PW'((64'd1 << npp_pkg::DSTW) - 64'd1);

  npp_pkg::state_t state, state_next, ret;

  logic signed [CW-1:0] anchor_x, anchor_y;
  logic signed [CW-1:0] prev_x, prev_y, bx, by, tx, ty;
  logic                 last_r;
  logic signed [MW-1:0] ux, uy, wx, wy;
  logic signed [PW-1:0] p, acc, num, den, cd, d1;
  logic signed [CW-1:0] best_x, best_y;
  logic signed [PW-1:0] best_d;
  logic                 best_valid;
  logic signed [MW-1:0] ma, mb, ex, ey;
  logic                 div_start, div_done;
  logic [npp_pkg::QW-1:0] quot;
  logic signed [MW-1:0] q_s;
  logic                 in_range;
  logic                 finish_go;
  logic                 result_taken;

  // Configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x <= '0;
      anchor_y <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == npp_pkg::ADDR_ANCHOR_X) anchor_x <= pwdata[CW-1:0];
      else if (paddr == npp_pkg::ADDR_ANCHOR_Y) anchor_y <= pwdata[CW-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == npp_pkg::ADDR_ANCHOR_X) prdata = 32'(anchor_x);
    else if (paddr == npp_pkg::ADDR_ANCHOR_Y) prdata = 32'(anchor_y);
  end

  assign vertex_stall = (state != npp_pkg::ST_IDLE);

  // Foot coordinate: base plus product scaled down, truncated toward zero
  function automatic logic signed [CW-1:0] foot(input logic signed [CW-1:0] a,
                                                input logic signed [PW-1:0] t);
    logic signed [PW-1:0] mag;
    logic signed [PW-1:0] sh;
    logic signed [PW-1:0] r;
    mag = t[PW-1] ? -t : t;
    sh  = mag >>> npp_pkg::RB;
    r   = t[PW-1] ? (PW'(a) - sh) : (PW'(a) + sh);
    return r[CW-1:0];
  endfunction

  assign ex       = MW'(anchor_x) - MW'(tx);
  assign ey       = MW'(anchor_y) - MW'(ty);
  assign q_s      = MW'(quot);
  assign in_range = (den != '0) && !num[PW-1] && (num <= den);

  // Select operands of the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      npp_pkg::ST_NUM0:  begin ma = wx;  mb = ux; end
      npp_pkg::ST_NUM1:  begin ma = wy;  mb = uy; end
      npp_pkg::ST_DEN0:  begin ma = ux;  mb = ux; end
      npp_pkg::ST_DEN1:  begin ma = uy;  mb = uy; end
      npp_pkg::ST_FOOT0: begin ma = q_s; mb = ux; end
      npp_pkg::ST_FOOT1: begin ma = q_s; mb = uy; end
      npp_pkg::ST_DIST0: begin ma = ex;  mb = ex; end
      npp_pkg::ST_DIST1: begin ma = ey;  mb = ey; end
      default:           begin ma = '0;  mb = '0; end
    endcase
  end

  always_ff @(posedge clk) p <= ma * mb;

  npp_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num[npp_pkg::DW-1:0]),
    .den  (den[npp_pkg::DW-1:0]),
    .done (div_done),
    .quot (quot)
  );

  // Next state
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      npp_pkg::ST_IDLE:
        if (vertex_valid) state_next = vertex.move_to ? npp_pkg::ST_FINISH : npp_pkg::ST_DIFF;
      npp_pkg::ST_DIFF:  state_next = npp_pkg::ST_NUM0;
      npp_pkg::ST_NUM0:  state_next = npp_pkg::ST_NUM1;
      npp_pkg::ST_NUM1:  state_next = npp_pkg::ST_DEN0;
      npp_pkg::ST_DEN0:  state_next = npp_pkg::ST_DEN1;
      npp_pkg::ST_DEN1:  state_next = npp_pkg::ST_DEN2;
      npp_pkg::ST_DEN2:  state_next = npp_pkg::ST_DECIDE;
      npp_pkg::ST_DECIDE: begin
        if (in_range) begin
          div_start  = 1'b1;
          state_next = npp_pkg::ST_DIV;
        end else begin
          state_next = npp_pkg::ST_DIST0;
        end
      end
      npp_pkg::ST_DIV:   if (div_done) state_next = npp_pkg::ST_FOOT0;
      npp_pkg::ST_FOOT0: state_next = npp_pkg::ST_FOOT1;
      npp_pkg::ST_FOOT1: state_next = npp_pkg::ST_FOOT2;
      npp_pkg::ST_FOOT2: state_next = npp_pkg::ST_DIST0;
      npp_pkg::ST_DIST0: state_next = npp_pkg::ST_DIST1;
      npp_pkg::ST_DIST1: state_next = npp_pkg::ST_DIST2;
      npp_pkg::ST_DIST2: state_next = ret;
      npp_pkg::ST_ENDB:  state_next = npp_pkg::ST_DIST0;
      npp_pkg::ST_PICK:  state_next = npp_pkg::ST_UPDATE;
      npp_pkg::ST_UPDATE: state_next = npp_pkg::ST_FINISH;
      npp_pkg::ST_FINISH:
        if (!(last_r && result_valid && result_stall)) state_next = npp_pkg::ST_IDLE;
      default: state_next = npp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= npp_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      npp_pkg::ST_IDLE: if (vertex_valid) begin
        last_r <= vertex.last_vertex;
        bx     <= vertex.vertex_x;
        by     <= vertex.vertex_y;
      end
      npp_pkg::ST_DIFF: begin
        ux <= MW'(bx) - MW'(prev_x);
        uy <= MW'(by) - MW'(prev_y);
        wx <= MW'(anchor_x) - MW'(prev_x);
        wy <= MW'(anchor_y) - MW'(prev_y);
      end
      npp_pkg::ST_NUM1: acc <= p;
      npp_pkg::ST_DEN0: num <= acc + p;
      npp_pkg::ST_DEN1: acc <= p;
      npp_pkg::ST_DEN2: den <= acc + p;
      npp_pkg::ST_DECIDE: if (!in_range) begin
        tx  <= prev_x;
        ty  <= prev_y;
        ret <= npp_pkg::ST_ENDB;
      end
      npp_pkg::ST_FOOT1: tx <= foot(prev_x, p);
      npp_pkg::ST_FOOT2: begin
        ty  <= foot(prev_y, p);
        ret <= npp_pkg::ST_UPDATE;
      end
      npp_pkg::ST_DIST1: acc <= p;
      npp_pkg::ST_DIST2: cd <= acc + p;
      npp_pkg::ST_ENDB: begin
        d1  <= cd;
        tx  <= bx;
        ty  <= by;
        ret <= npp_pkg::ST_PICK;
      end
      npp_pkg::ST_PICK: if (d1 < cd) begin
        tx <= prev_x;
        ty <= prev_y;
        cd <= d1;
      end
      default: ;
    endcase
  end

  assign finish_go    = (state == npp_pkg::ST_FINISH) && !(last_r && result_valid && result_stall);
  assign result_taken = result_valid && !result_stall;

  // Running best, previous point and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x       <= '0;
      prev_y       <= '0;
      best_x       <= '0;
      best_y       <= '0;
      best_d       <= DIST_MAX;
      best_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (state == npp_pkg::ST_UPDATE && cd < best_d) begin
        best_x     <= tx;
        best_y     <= ty;
        best_d     <= cd;
        best_valid <= 1'b1;
      end
      if (finish_go && last_r) begin
        result_valid            <= 1'b1;
        result.found            <= best_valid;
        result.nearest_x        <= best_valid ? best_x : '0;
        result.nearest_y        <= best_valid ? best_y : '0;
        result.distance_squared <= best_valid ? best_d[npp_pkg::DSTW-1:0] : '0;
        prev_x     <= '0;
        prev_y     <= '0;
        best_x     <= '0;
        best_y     <= '0;
        best_d     <= DIST_MAX;
        best_valid <= 1'b0;
      end else begin
        if (finish_go) begin
          prev_x <= bx;
          prev_y <= by;
        end
        if (result_taken) result_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

>>> src/npp_divider.sv
// Restoring divider: one quotient bit per cycle for the projection ratio.
`default_nettype none
module npp_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [npp_pkg::DW-1:0]      num,
  input  wire logic [npp_pkg::DW-1:0]      den,
  output logic                             done,
  output logic [npp_pkg::QW-1:0]           quot
);
  localparam int CNTW = $clog2(npp_pkg::RB + 1);

  logic                    busy;
  logic [CNTW-1:0]         cnt;
  logic [npp_pkg::DW:0]    rem;
  logic [npp_pkg::DW:0]    den_r;
  logic [npp_pkg::DW:0]    rem_sh;
  logic                    q0;

  assign q0     = (num >= den);
  assign rem_sh = {rem[npp_pkg::DW-1:0], 1'b0};

  // Seed integer bit, then shift in one fraction bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNTW'(npp_pkg::RB);
        den_r <= {1'b0, den};
        quot  <= {{(npp_pkg::QW-1){1'b0}}, q0};
        rem   <= q0 ? {1'b0, num - den} : {1'b0, num};
      end else if (busy) begin
        if (rem_sh >= den_r) begin
          rem  <= rem_sh - den_r;
          quot <= {quot[npp_pkg::QW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          quot <= {quot[npp_pkg::QW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> tb/nearest_point_on_polyline_top_tb.sv
// Testbench for the nearest-point-on-polyline block: directed table, random paths, scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module nearest_point_on_polyline_top_tb;
  localparam int LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vertex_valid = 1'b0;
  logic vertex_stall;
  npp_pkg::vertex_t vertex = '0;
  logic result_valid;
  logic result_stall = 1'b1;
  npp_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [npp_pkg::AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  nearest_point_on_polyline_top u_dut (
    .clk(clk), .rst(rst),
    .vertex_valid(vertex_valid), .vertex_stall(vertex_stall), .vertex(vertex),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  longint anc_x, anc_y, prev_x, prev_y, near_x, near_y;
  longint unsigned near_dist;
  bit near_valid;

  npp_pkg::result_t nearest_q[$];
  int errors = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int paths_sent = 0;
  longint cycles = 0;
  bit long_hold = 1'b0;

  typedef struct {
    bit move;
    int x;
    int y;
    bit last;
    bit typed;
    npp_pkg::result_t want;
  } row_t;

  function automatic longint sx(logic [npp_pkg::CW-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned dist_sq(longint px, longint py, longint qx, longint qy);
    return longint'((px - qx) * (px - qx)) + longint'((py - qy) * (py - qy));
  endfunction

  function automatic longint foot_coord(longint a, longint d, longint rq);
    longint t;
    t = rq * d;
    if (t < 0) return a - ((-t) >>> npp_pkg::RB);
    return a + (t >>> npp_pkg::RB);
  endfunction

  function automatic void clear_path();
    prev_x = 0; prev_y = 0; near_x = 0; near_y = 0;
    near_dist = (64'd1 << npp_pkg::DSTW) - 1;
    near_valid = 1'b0;
  endfunction

  function automatic void project_segment(longint bx, longint by);
    longint ux, uy, num, den, cx, cy, q, rem;
    longint unsigned cd, d1, d2;
    ux = bx - prev_x; uy = by - prev_y;
    num = (anc_x - prev_x) * ux + (anc_y - prev_y) * uy;
    den = ux * ux + uy * uy;
    if (den > 0 && num >= 0 && num <= den) begin
      q = (num >= den) ? 1 : 0;
      rem = num - q * den;
      for (int i = 0; i < npp_pkg::RB; i++) begin
        rem = rem <<< 1;
        q = q <<< 1;
        if (rem >= den) begin
          rem -= den;
          q |= 1;
        end
      end
      cx = foot_coord(prev_x, ux, q);
      cy = foot_coord(prev_y, uy, q);
      cd = dist_sq(anc_x, anc_y, cx, cy);
    end else begin
      d1 = dist_sq(anc_x, anc_y, prev_x, prev_y);
      d2 = dist_sq(anc_x, anc_y, bx, by);
      if (d1 < d2) begin
        cx = prev_x; cy = prev_y; cd = d1;
      end else begin
        cx = bx; cy = by; cd = d2;
      end
    end
    if (cd < near_dist) begin
      near_x = cx; near_y = cy; near_dist = cd; near_valid = 1'b1;
    end
  endfunction

  // advance the predictor by one request; returns 1 with the result on a last vertex
  function automatic bit predict_nearest(npp_pkg::vertex_t v, output npp_pkg::result_t r);
    r = '0;
    if (!v.move_to) project_segment(sx(v.vertex_x), sx(v.vertex_y));
    prev_x = sx(v.vertex_x);
    prev_y = sx(v.vertex_y);
    if (!v.last_vertex) return 1'b0;
    if (near_valid) begin
      r.nearest_x = near_x[npp_pkg::CW-1:0];
      r.nearest_y = near_y[npp_pkg::CW-1:0];
      r.distance_squared = near_dist[npp_pkg::DSTW-1:0];
      r.found = 1'b1;
    end
    clear_path();
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // compare a result field by field
  task automatic check_result(string tag, npp_pkg::result_t got, npp_pkg::result_t want);
    if (got.nearest_x !== want.nearest_x)
      report_mismatch({tag, " nearest_x"}, sx(got.nearest_x), sx(want.nearest_x));
    if (got.nearest_y !== want.nearest_y)
      report_mismatch({tag, " nearest_y"}, sx(got.nearest_y), sx(want.nearest_y));
    if (got.distance_squared !== want.distance_squared)
      report_mismatch({tag, " distance_squared"}, longint'(got.distance_squared),
                      longint'(want.distance_squared));
    if (got.found !== want.found)
      report_mismatch({tag, " found"}, longint'(got.found), longint'(want.found));
  endtask

  // register write with setup and access phases; block must be idle
  task automatic write_anchor(logic [npp_pkg::AW-1:0] addr, int value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == npp_pkg::ADDR_ANCHOR_X) anc_x = longint'(value);
    else if (addr == npp_pkg::ADDR_ANCHOR_Y) anc_y = longint'(value);
  endtask

  task automatic set_anchor(int ax, int ay);
    write_anchor(npp_pkg::ADDR_ANCHOR_X, ax);
    write_anchor(npp_pkg::ADDR_ANCHOR_Y, ay);
  endtask

  // drop the request, hold until every result is in, then let the block drain
  task automatic wait_idle();
    vertex_valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // offer one request after a random gap and hold it until accepted
  task automatic send_vertex(bit move, int x, int y, bit last, bit typed,
                             npp_pkg::result_t want);
    npp_pkg::vertex_t v;
    npp_pkg::result_t r;
    int gap;
    v.move_to = move;
    v.vertex_x = x[npp_pkg::CW-1:0];
    v.vertex_y = y[npp_pkg::CW-1:0];
    v.last_vertex = last;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      vertex_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vertex_valid <= 1'b1;
    vertex <= v;
    @(posedge clk);
    while (vertex_stall) @(posedge clk);
    requests_sent++;
    if (predict_nearest(v, r)) begin
      if (typed) check_result("table entry vs predictor", r, want);
      nearest_q.push_back(r);
      paths_sent++;
    end
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return -524288;
      1: return 524287;
      2: return int'($urandom_range(0, 64)) - 32;
      default: return int'($urandom_range(0, 1048575)) - 524288;
    endcase
  endfunction

  // receive side: random wait per result, one long hold-off, field-by-field check
  initial begin
    npp_pkg::result_t want;
    int wait_n;
    @(negedge rst);
    forever begin
      wait_n = $urandom_range(0, 19);
      if (long_hold) begin
        wait_n = 3000;
        long_hold = 1'b0;
      end
      if (wait_n > 0) begin
        result_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      results_seen++;
      if (nearest_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result", $realtime);
      end else begin
        want = nearest_q.pop_front();
        check_result("result", result, want);
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  row_t dir_rows[$];

  task automatic add_row(bit move, int x, int y, bit last, bit typed,
                         npp_pkg::result_t want);
    row_t r;
    r.move = move; r.x = x; r.y = y; r.last = last; r.typed = typed; r.want = want;
    dir_rows.push_back(r);
  endtask

  initial begin
    npp_pkg::result_t none_r, end_r;
    int n_path, len;
    none_r = '0;
    anc_x = 0; anc_y = 0;
    clear_path();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, anchor at origin
    add_row(1'b1, 100, 100, 1'b1, 1'b1, none_r);           // move-to only path
    add_row(1'b0, 0, 0, 1'b1, 1'b0, none_r);                // zero-length from origin
    end_r = '0;
    end_r.nearest_x = 20'h7FFFF;
    end_r.nearest_y = 20'h80000;
    end_r.distance_squared = 41'd549754765313;
    end_r.found = 1'b1;
    add_row(1'b1, 524287, -524288, 1'b0, 1'b0, none_r);
    add_row(1'b0, 524287, -524288, 1'b1, 1'b1, end_r);      // far zero-length segment
    add_row(1'b0, -524288, 524287, 1'b0, 1'b0, none_r);     // segment before move-to
    add_row(1'b0, 524287, 524287, 1'b0, 1'b0, none_r);
    add_row(1'b1, -524288, -524288, 1'b1, 1'b0, none_r);    // move-to on last vertex
    add_row(1'b1, -50, 30, 1'b0, 1'b0, none_r);
    add_row(1'b0, 50, 30, 1'b0, 1'b0, none_r);              // foot inside
    add_row(1'b0, 50, -30, 1'b0, 1'b0, none_r);
    add_row(1'b0, 10, 10, 1'b1, 1'b0, none_r);
    add_row(1'b1, 10, 0, 1'b0, 1'b0, none_r);
    add_row(1'b0, -10, 0, 1'b1, 1'b0, none_r);               // anchor on segment
    add_row(1'b1, 0, 5, 1'b0, 1'b0, none_r);
    add_row(1'b0, 0, -5, 1'b0, 1'b0, none_r);                // tie with the next segment
    add_row(1'b0, 0, 5, 1'b1, 1'b0, none_r);
    add_row(1'b1, 40, 40, 1'b0, 1'b0, none_r);
    add_row(1'b0, 80, 80, 1'b1, 1'b0, none_r);               // endpoint wins
    foreach (dir_rows[i])
      send_vertex(dir_rows[i].move, dir_rows[i].x, dir_rows[i].y, dir_rows[i].last,
                  dir_rows[i].typed, dir_rows[i].want);
    wait_idle();

    // random paths under several anchors, extremes first
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_anchor(524287, -524288);
        1: set_anchor(-524288, 524287);
        2: set_anchor(0, 0);
        default: set_anchor(int'($urandom_range(0, 1048575)) - 524288,
                            int'($urandom_range(0, 1048575)) - 524288);
      endcase
      n_path = 0;
      while (n_path < 18) begin
        if (phase == 3 && n_path == 2) long_hold = 1'b1;
        len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
        for (int k = 0; k < len; k++) begin
          send_vertex((k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 9) == 0),
                      ($urandom_range(0, 3) == 0) ? rand_coord()
                        : int'($urandom_range(0, 1048575)) - 524288,
                      ($urandom_range(0, 3) == 0) ? rand_coord()
                        : int'($urandom_range(0, 1048575)) - 524288,
                      k == len - 1, 1'b0, none_r);
        end
        n_path++;
      end
      wait_idle();
    end

    $display("sent %0d vertex requests in %0d paths, checked %0d results",
             requests_sent, paths_sent, results_seen);
    $display("anchors covered both coordinate extremes and random settings");
    if (errors == 0 && nearest_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
